/* rtl/vrpc_pkg.sv */
// ----------------------------------------------------------------------------
// vrpc_pkg
// Shared types, action codes and the intensity table of the video RAM and
// palette controller.
// ----------------------------------------------------------------------------
package vrpc_pkg;

    typedef logic [3:0] t_action;

    localparam t_action ACT_DIRECT_RD  = 4'd0;
    localparam t_action ACT_DIRECT_WR  = 4'd1;
    localparam t_action ACT_LATCH_RD   = 4'd2;
    localparam t_action ACT_LATCH_WR   = 4'd3;
    localparam t_action ACT_ADDR_HI    = 4'd4;
    localparam t_action ACT_ADDR_LO    = 4'd5;
    localparam t_action ACT_MASK_WR    = 4'd6;
    localparam t_action ACT_PAL_WR     = 4'd7;
    localparam t_action ACT_PAL_RD     = 4'd8;
    localparam t_action ACT_BANK_WR    = 4'd9;
    localparam t_action ACT_PIXEL      = 4'd10;

    localparam logic CFG_BLEND_MODE  = 1'b0;
    localparam logic CFG_FLIP_SCREEN = 1'b1;

    localparam logic [7:0] LED_MASK = 8'hFC;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MERGE,
        S_PIXPAL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        AS_WINDOW,
        AS_LATCH,
        AS_PIXEL
    } t_addr_sel;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_VIDEO,
        RD_PAL
    } t_rd_sel;

    typedef struct packed {
        logic      item_load;
        logic      vid_rd;
        logic      vid_wr;
        logic      vid_merge;
        t_addr_sel addr_sel;
        logic      pal_wr;
        logic      pal_rd_bus;
        logic      pal_rd_pix;
        logic      ah_wr;
        logic      al_wr;
        logic      mask_wr;
        logic      bank_wr;
        logic      out_load;
        t_rd_sel   rd_sel;
        logic      rgb_en;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    blend;
        logic    out_free;
    } t_sts;

    function automatic logic [7:0] intensity(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h12;
            4'd2:    v = 8'h24;
            4'd3:    v = 8'h49;
            4'd4:    v = 8'h12;
            4'd5:    v = 8'h24;
            4'd6:    v = 8'h49;
            4'd7:    v = 8'h92;
            4'd8:    v = 8'h5b;
            4'd9:    v = 8'h6d;
            4'd10:   v = 8'h92;
            4'd11:   v = 8'hdb;
            4'd12:   v = 8'h7f;
            4'd13:   v = 8'h91;
            4'd14:   v = 8'hb6;
            default: v = 8'hff;
        endcase
        return v;
    endfunction

endpackage

/* rtl/vrpc_ctrl.sv */
// ----------------------------------------------------------------------------
// vrpc_ctrl
// Sequencer: steps one access through execute, merge, palette lookup and
// result hand-off, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module vrpc_ctrl
    import vrpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_item_valid,
    output logic o_item_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.addr_sel = AS_WINDOW;
        o_cmd.rd_sel   = RD_NONE;
        o_item_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_item_ready    = 1'b1;
                o_cmd.item_load = i_item_valid;
                if (i_item_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_sts.action)
                    ACT_DIRECT_RD: begin
                        o_cmd.vid_rd = 1'b1;
                    end
                    ACT_DIRECT_WR: begin
                        if (i_sts.blend) begin
                            o_cmd.vid_rd = 1'b1;
                            n_state      = S_MERGE;
                        end else begin
                            o_cmd.vid_wr = 1'b1;
                        end
                    end
                    ACT_LATCH_RD: begin
                        o_cmd.addr_sel = AS_LATCH;
                        o_cmd.vid_rd   = 1'b1;
                    end
                    ACT_LATCH_WR: begin
                        o_cmd.addr_sel = AS_LATCH;
                        if (i_sts.blend) begin
                            o_cmd.vid_rd = 1'b1;
                            n_state      = S_MERGE;
                        end else begin
                            o_cmd.vid_wr = 1'b1;
                        end
                    end
                    ACT_ADDR_HI: o_cmd.ah_wr      = 1'b1;
                    ACT_ADDR_LO: o_cmd.al_wr      = 1'b1;
                    ACT_MASK_WR: o_cmd.mask_wr    = 1'b1;
                    ACT_PAL_WR:  o_cmd.pal_wr     = 1'b1;
                    ACT_PAL_RD:  o_cmd.pal_rd_bus = 1'b1;
                    ACT_BANK_WR: o_cmd.bank_wr    = 1'b1;
                    ACT_PIXEL: begin
                        o_cmd.addr_sel = AS_PIXEL;
                        o_cmd.vid_rd   = 1'b1;
                        n_state        = S_PIXPAL;
                    end
                    default: ;
                endcase
            end
            S_MERGE: begin
                o_cmd.vid_merge = 1'b1;
                o_cmd.addr_sel  = (i_sts.action == ACT_DIRECT_WR) ? AS_WINDOW : AS_LATCH;
                n_state         = S_DONE;
            end
            S_PIXPAL: begin
                o_cmd.pal_rd_pix = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                case (i_sts.action)
                    ACT_DIRECT_RD: o_cmd.rd_sel = RD_VIDEO;
                    ACT_LATCH_RD:  o_cmd.rd_sel = RD_VIDEO;
                    ACT_PAL_RD:    o_cmd.rd_sel = RD_PAL;
                    ACT_PIXEL:     o_cmd.rgb_en = 1'b1;
                    default: ;
                endcase
                o_cmd.out_load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/vrpc_dp.sv */
// ----------------------------------------------------------------------------
// vrpc_dp
// Datapath: item and latch registers, video and palette memories, merge,
// pixel address forming, intensity lookup and the output register.
// ----------------------------------------------------------------------------
module vrpc_dp
    import vrpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [53:0] i_item,
    input  logic        i_cfg_wr,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [39:0] o_out_data
);

    logic [7:0] r_vmem [65536];
    logic [7:0] r_pmem [1024];

    t_action     r_action;
    logic [14:0] r_bus;
    logic [7:0]  r_wdata;
    logic [13:0] r_ma;
    logic [4:0]  r_ra;
    logic [7:0]  r_col;

    logic [7:0]  r_ah;
    logic [7:0]  r_al;
    logic [7:0]  r_mask;
    logic [1:0]  r_bank;
    logic [7:0]  r_led;
    logic        r_blend;
    logic        r_flip;

    logic [7:0]  r_vrd;
    logic [7:0]  r_prd;

    logic        r_out_valid;
    logic [39:0] r_out_data;

    logic [15:0] vaddr;
    logic [7:0]  vwdata;
    logic [9:0]  paddr;
    logic [7:0]  rd;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_action <= i_item[3:0];
            r_bus    <= i_item[18:4];
            r_wdata  <= i_item[26:19];
            r_ma     <= i_item[40:27];
            r_ra     <= i_item[45:41];
            r_col    <= i_item[53:46];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ah    <= '0;
            r_al    <= '0;
            r_mask  <= '0;
            r_bank  <= '0;
            r_led   <= '0;
            r_blend <= 1'b0;
            r_flip  <= 1'b0;
        end else begin
            if (i_cmd.ah_wr) begin
                r_ah <= r_wdata;
            end
            if (i_cmd.al_wr) begin
                r_al <= r_wdata;
            end
            if (i_cmd.mask_wr) begin
                r_mask <= r_wdata;
            end
            if (i_cmd.bank_wr) begin
                r_bank <= r_wdata[1:0];
                r_led  <= ~r_wdata & LED_MASK;
            end
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    CFG_BLEND_MODE:  r_blend <= i_cfg_data;
                    CFG_FLIP_SCREEN: r_flip  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (i_cmd.addr_sel)
            AS_WINDOW: vaddr = {r_ah[7], r_bus};
            AS_LATCH:  vaddr = {r_ah, r_al};
            AS_PIXEL:  vaddr = {r_ma[9:5], r_ra[2:0], r_col} ^ {16{r_flip}};
            default:   vaddr = {r_ah, r_al};
        endcase
    end

    assign vwdata = i_cmd.vid_merge ? ((r_vrd & ~r_mask) | (r_wdata & r_mask)) : r_wdata;
    assign paddr  = i_cmd.pal_rd_pix ? {r_bank, r_vrd} : r_bus[9:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.vid_wr || i_cmd.vid_merge) begin
            r_vmem[vaddr] <= vwdata;
        end
        if (i_cmd.vid_rd) begin
            r_vrd <= r_vmem[vaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pal_wr) begin
            r_pmem[paddr] <= r_wdata;
        end
        if (i_cmd.pal_rd_bus || i_cmd.pal_rd_pix) begin
            r_prd <= r_pmem[paddr];
        end
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_VIDEO: rd = r_vrd;
            RD_PAL:   rd = r_prd;
            default:  rd = '0;
        endcase
        red   = i_cmd.rgb_en ? intensity({r_prd[7:6], r_prd[1:0]}) : 8'h00;
        green = i_cmd.rgb_en ? intensity({r_prd[5:4], r_prd[1:0]}) : 8'h00;
        blue  = i_cmd.rgb_en ? intensity({r_prd[3:2], r_prd[1:0]}) : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_led, blue, green, red, rd};
        end
    end

    assign o_sts.action   = r_action;
    assign o_sts.blend    = r_blend;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

/* rtl/video_ram_palette_controller.sv */
// ----------------------------------------------------------------------------
// video_ram_palette_controller
// Idle takes an item, then execute and done, which loads the result when the
// output is free; blended writes add a merge state, pixel fetches a palette
// state (video read, then palette read). A new item is taken only after the
// last has left done; the memories are single-port and used in sequence.
// Reset clears latches, mask, bank, LED and config; memories are not cleared.
// ----------------------------------------------------------------------------
module video_ram_palette_controller
    import vrpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[3:0], bus_address[18:4], write_data[26:19],
    // crtc_memory_address[40:27], crtc_row_address[45:41], pixel_column[53:46]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], red[15:8], green[23:16], blue[31:24], led_drive[39:32]
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    vrpc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    vrpc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (s_axis_tdata[53:0]),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
